FILE: rtl/rtcseq_pkg.sv
// ---------------------------------------------------------------------------
// rtcseq_pkg
// Types and constants shared by the RTC transaction sequencer modules.
// ---------------------------------------------------------------------------
package rtcseq_pkg;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_WR   = 4'd1,
    PH_START_RD   = 4'd2,
    PH_RESTART_RD = 4'd3,
    PH_ADDR_WR    = 4'd4,
    PH_ADDR_RDWR  = 4'd5,
    PH_ADDR_RDRD  = 4'd6,
    PH_YEAR       = 4'd7,
    PH_SEND_VAL   = 4'd8,
    PH_STOP_WR    = 4'd9,
    PH_SEC        = 4'd10,
    PH_MIN        = 4'd11,
    PH_HOUR       = 4'd12,
    PH_DAY        = 4'd13,
    PH_WDAY       = 4'd14
  } phase_t;

  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_EVENT  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [5:0] ACT_START   = 6'b00_0001;
  localparam logic [5:0] ACT_STOP    = 6'b00_0010;
  localparam logic [5:0] ACT_ACK     = 6'b00_0100;
  localparam logic [5:0] ACT_SEND    = 6'b00_1000;
  localparam logic [5:0] ACT_BUF_ON  = 6'b01_0000;
  localparam logic [5:0] ACT_BUF_OFF = 6'b10_0000;

  localparam logic [2:0] PF_UPDATE = 3'b001;
  localparam logic [2:0] PF_WRITE  = 3'b010;
  localparam logic [2:0] PF_ERROR  = 3'b100;

  localparam logic [7:0] FIRST_TIME_REG = 8'h02;
  localparam logic [7:0] MAX_TARGET     = 8'd15;

  localparam logic [7:0] MASK_SEC   = 8'h7F;
  localparam logic [7:0] MASK_MIN   = 8'h7F;
  localparam logic [7:0] MASK_HOUR  = 8'h3F;
  localparam logic [7:0] MASK_DAY   = 8'h3F;
  localparam logic [7:0] MASK_WDAY  = 8'h07;
  localparam logic [7:0] MASK_MONTH = 8'h1F;

  localparam int unsigned TIME_REGS = 7;

  localparam logic CFG_WRITE_ADDR = 1'b0;
  localparam logic CFG_READ_ADDR  = 1'b1;

  localparam logic [7:0] RESET_WRITE_ADDR = 8'hA2;
  localparam logic [7:0] RESET_READ_ADDR  = 8'hA3;

  typedef logic [7:0] time_regs_t [TIME_REGS];

  typedef struct packed {
    logic [5:0] actions;
    logic [7:0] tx_byte;
    logic [7:0] seconds_bcd;
    logic [7:0] minutes_bcd;
    logic [7:0] hours_bcd;
    logic [7:0] day_bcd;
    logic [7:0] weekday_value;
    logic [7:0] month_bcd;
    logic [7:0] year_bcd;
    logic       all_done;
    logic       error_flag;
    logic       write_accepted;
  } result_t;

endpackage

FILE: rtl/rtcseq_engine.sv
// ---------------------------------------------------------------------------
// rtcseq_engine
// Transaction state, pending requests, time store and the decode of one
// request or controller event into commands and a result.
// ---------------------------------------------------------------------------
module rtcseq_engine
  import rtcseq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       accept,
  input  logic [1:0] mode,
  input  logic [7:0] target_register,
  input  logic [7:0] write_data,
  input  logic       flag_start_sent,
  input  logic       flag_address_sent,
  input  logic       flag_rx_not_empty,
  input  logic       flag_byte_done,
  input  logic       flag_tx_empty,
  input  logic       bus_error,
  input  logic [7:0] rx_byte,
  input  logic [7:0] rx_byte_next,
  output result_t    result
);

  logic [7:0] device_write_address;
  logic [7:0] device_read_address;
  phase_t     phase;
  logic [2:0] pending_flags;
  logic [3:0] pending_register;
  logic [7:0] pending_value;
  time_regs_t time_store;

  phase_t     phase_next;
  logic [2:0] pending_flags_next;
  logic [3:0] pending_register_next;
  logic [7:0] pending_value_next;
  time_regs_t time_store_next;
  logic [5:0] acts;
  logic [7:0] txb;
  logic       accepted;

  always_comb begin
    phase_next            = phase;
    pending_flags_next    = pending_flags;
    pending_register_next = pending_register;
    pending_value_next    = pending_value;
    time_store_next       = time_store;
    acts                  = '0;
    txb                   = '0;
    accepted              = 1'b0;

    unique case (mode)
      MODE_UPDATE: begin
        pending_flags_next = pending_flags_next | PF_UPDATE;
      end
      MODE_WRITE: begin
        if (((pending_flags & PF_WRITE) == '0) && (target_register <= MAX_TARGET)) begin
          pending_register_next = target_register[3:0];
          pending_value_next    = write_data;
          pending_flags_next    = pending_flags_next | PF_WRITE;
          accepted              = 1'b1;
        end
      end
      MODE_EVENT: begin
        if (bus_error) begin
          phase_next         = PH_IDLE;
          pending_flags_next = PF_ERROR;
        end
        if (flag_start_sent) begin
          unique case (phase_next)
            PH_START_WR: begin
              acts       = acts | ACT_SEND;
              txb        = device_write_address;
              phase_next = PH_ADDR_WR;
            end
            PH_START_RD: begin
              acts       = acts | ACT_SEND;
              txb        = device_write_address;
              phase_next = PH_ADDR_RDWR;
            end
            PH_RESTART_RD: begin
              acts       = acts | ACT_SEND;
              txb        = device_read_address;
              phase_next = PH_ADDR_RDRD;
            end
            default: ;
          endcase
        end
        if (flag_address_sent) begin
          unique case (phase_next)
            PH_ADDR_WR: begin
              acts       = acts | ACT_SEND;
              txb        = {4'd0, pending_register_next};
              phase_next = PH_SEND_VAL;
            end
            PH_ADDR_RDWR: begin
              acts       = acts | ACT_SEND | ACT_START | ACT_STOP;
              txb        = FIRST_TIME_REG;
              phase_next = PH_RESTART_RD;
            end
            PH_ADDR_RDRD: begin
              acts       = acts | ACT_ACK;
              phase_next = PH_SEC;
            end
            default: ;
          endcase
        end
        if (flag_rx_not_empty) begin
          if (phase_next == PH_YEAR) begin
            time_store_next[6] = rx_byte;
            time_store_next[0] = time_store_next[0] & MASK_SEC;
            time_store_next[1] = time_store_next[1] & MASK_MIN;
            time_store_next[2] = time_store_next[2] & MASK_HOUR;
            time_store_next[3] = time_store_next[3] & MASK_DAY;
            time_store_next[4] = time_store_next[4] & MASK_WDAY;
            time_store_next[5] = time_store_next[5] & MASK_MONTH;
            phase_next         = PH_IDLE;
            pending_flags_next = pending_flags_next & ~(PF_UPDATE | PF_ERROR);
          end
          acts = acts | ACT_BUF_OFF;
        end
        if (flag_byte_done) begin
          unique case (phase_next)
            PH_SEND_VAL: begin
              if (flag_tx_empty) begin
                acts       = acts | ACT_SEND;
                txb        = pending_value_next;
                phase_next = PH_STOP_WR;
              end
            end
            PH_STOP_WR: begin
              acts               = acts | ACT_STOP;
              phase_next         = PH_IDLE;
              pending_flags_next = pending_flags_next & ~(PF_WRITE | PF_ERROR);
            end
            PH_SEC: begin
              time_store_next[0] = rx_byte;
              acts               = acts | ACT_ACK;
              phase_next         = PH_MIN;
            end
            PH_MIN: begin
              time_store_next[1] = rx_byte;
              acts               = acts | ACT_ACK;
              phase_next         = PH_HOUR;
            end
            PH_HOUR: begin
              time_store_next[2] = rx_byte;
              acts               = acts | ACT_ACK;
              phase_next         = PH_DAY;
            end
            PH_DAY: begin
              time_store_next[3] = rx_byte;
              acts               = acts | ACT_ACK;
              phase_next         = PH_WDAY;
            end
            PH_WDAY: begin
              time_store_next[4] = rx_byte;
              time_store_next[5] = rx_byte_next;
              acts               = acts | ACT_STOP | ACT_BUF_ON;
              phase_next         = PH_YEAR;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // an idle sequencer opens the next transaction, update first
    if ((mode != MODE_UNUSED) && (phase_next == PH_IDLE)) begin
      if ((pending_flags_next & PF_UPDATE) != '0) begin
        phase_next = PH_START_RD;
        acts       = acts | ACT_START;
      end else if ((pending_flags_next & PF_WRITE) != '0) begin
        phase_next = PH_START_WR;
        acts       = acts | ACT_START;
      end
    end
  end

  always_comb begin
    result.actions        = acts;
    result.tx_byte        = ((acts & ACT_SEND) != '0) ? txb : 8'd0;
    result.seconds_bcd    = time_store_next[0];
    result.minutes_bcd    = time_store_next[1];
    result.hours_bcd      = time_store_next[2];
    result.day_bcd        = time_store_next[3];
    result.weekday_value  = time_store_next[4];
    result.month_bcd      = time_store_next[5];
    result.year_bcd       = time_store_next[6];
    result.all_done       = ((pending_flags_next & (PF_UPDATE | PF_WRITE)) == '0);
    result.error_flag     = ((pending_flags_next & PF_ERROR) != '0);
    result.write_accepted = accepted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_write_address <= RESET_WRITE_ADDR;
      device_read_address  <= RESET_READ_ADDR;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WRITE_ADDR: device_write_address <= cfg_data;
        CFG_READ_ADDR:  device_read_address  <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      pending_flags    <= '0;
      pending_register <= '0;
      pending_value    <= '0;
      for (int k = 0; k < TIME_REGS; k++) begin
        time_store[k] <= '0;
      end
    end else if (accept) begin
      phase            <= phase_next;
      pending_flags    <= pending_flags_next;
      pending_register <= pending_register_next;
      pending_value    <= pending_value_next;
      time_store       <= time_store_next;
    end
  end

endmodule

FILE: rtl/rtcseq_out_buf.sv
// ---------------------------------------------------------------------------
// rtcseq_out_buf
// Result register with a skid stage so the input side stays open while
// one result waits to be taken.
// ---------------------------------------------------------------------------
module rtcseq_out_buf
  import rtcseq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    drain;

  assign drain = out_valid && !out_stall;
  assign full  = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (!out_valid || drain) begin
        out_valid  <= skid_valid || push;
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end else begin
        skid_valid <= skid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (!out_valid || drain) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end else begin
      skid_data <= skid_data;
    end
  end

endmodule

FILE: rtl/i2c_rtc_transaction_sequencer_core.sv
// ---------------------------------------------------------------------------
// i2c_rtc_transaction_sequencer_core
// Sequences I2C master transactions to a real-time clock: time burst reads,
// single register writes, bus error abort.
// ---------------------------------------------------------------------------
// channel   handshake            payload
// input     in_valid / in_stall  mode, target_register, write_data, flags, rx bytes
// output    out_valid / out_stall actions, tx_byte, time registers, status
// config    cfg_write            cfg_index, cfg_data
//
// one input transfer per clock while in_stall is low; its result is registered
// a result register plus one skid entry; in_stall rises only when both hold
// results and the output side is stalled
// reset is synchronous; it returns the addresses to defaults, phase to idle
// and clears pending requests and the time store
// ---------------------------------------------------------------------------
module i2c_rtc_transaction_sequencer_core
  import rtcseq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] target_register,
  input  logic [7:0] write_data,
  input  logic       flag_start_sent,
  input  logic       flag_address_sent,
  input  logic       flag_rx_not_empty,
  input  logic       flag_byte_done,
  input  logic       flag_tx_empty,
  input  logic       bus_error,
  input  logic [7:0] rx_byte,
  input  logic [7:0] rx_byte_next,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] actions,
  output logic [7:0] tx_byte,
  output logic [7:0] seconds_bcd,
  output logic [7:0] minutes_bcd,
  output logic [7:0] hours_bcd,
  output logic [7:0] day_bcd,
  output logic [7:0] weekday_value,
  output logic [7:0] month_bcd,
  output logic [7:0] year_bcd,
  output logic       all_done,
  output logic       error_flag,
  output logic       write_accepted
);

  logic    accept;
  logic    buf_full;
  result_t step_result;
  result_t out_data;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  rtcseq_engine u_engine (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .accept            (accept),
    .mode              (mode),
    .target_register   (target_register),
    .write_data        (write_data),
    .flag_start_sent   (flag_start_sent),
    .flag_address_sent (flag_address_sent),
    .flag_rx_not_empty (flag_rx_not_empty),
    .flag_byte_done    (flag_byte_done),
    .flag_tx_empty     (flag_tx_empty),
    .bus_error         (bus_error),
    .rx_byte           (rx_byte),
    .rx_byte_next      (rx_byte_next),
    .result            (step_result)
  );

  rtcseq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign actions        = out_data.actions;
  assign tx_byte        = out_data.tx_byte;
  assign seconds_bcd    = out_data.seconds_bcd;
  assign minutes_bcd    = out_data.minutes_bcd;
  assign hours_bcd      = out_data.hours_bcd;
  assign day_bcd        = out_data.day_bcd;
  assign weekday_value  = out_data.weekday_value;
  assign month_bcd      = out_data.month_bcd;
  assign year_bcd       = out_data.year_bcd;
  assign all_done       = out_data.all_done;
  assign error_flag     = out_data.error_flag;
  assign write_accepted = out_data.write_accepted;

endmodule

FILE: rtl/rtcseq_checker.sv
// ---------------------------------------------------------------------------
// rtcseq_checker
// Port level checks for the RTC transaction sequencer.
// ---------------------------------------------------------------------------
module rtcseq_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] actions,
  input logic [7:0] tx_byte,
  input logic       all_done,
  input logic       write_accepted
);

  // a held result keeps its transfer pending
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // the input side closes only behind a waiting result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && $past(out_valid))
    else $error("input stalled with no result waiting");

  // no byte shown unless a send is commanded
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !actions[3] |-> tx_byte == 8'd0)
    else $error("tx byte without send command");

  // an accepted write leaves a request pending
  assert property (@(posedge clk) disable iff (rst)
    out_valid && write_accepted |-> !all_done && actions[5:4] == 2'b00)
    else $error("accepted write reported done");

endmodule

bind i2c_rtc_transaction_sequencer_core rtcseq_checker u_rtcseq_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .actions        (actions),
  .tx_byte        (tx_byte),
  .all_done       (all_done),
  .write_accepted (write_accepted)
);

FILE: verif/i2c_rtc_transaction_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_rtc_transaction_sequencer_core_tb
// Self-checking bench for the RTC transaction sequencer. A directed opening
// walks a full time burst, a register write and the abort and reject cases.
// It is followed by random traffic that mostly follows the controller
// protocol, with noise, bus errors and address register changes. Every
// result is checked against a predictor in this file.
// ---------------------------------------------------------------------------
module i2c_rtc_transaction_sequencer_core_tb
  import rtcseq_pkg::*;
;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int SHOW_LIMIT  = 10;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] target_register;
    logic [7:0] write_data;
    logic       flag_start_sent;
    logic       flag_address_sent;
    logic       flag_rx_not_empty;
    logic       flag_byte_done;
    logic       flag_tx_empty;
    logic       bus_error;
    logic [7:0] rx_byte;
    logic [7:0] rx_byte_next;
  } item_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic       cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] mode;
  logic [7:0] target_register;
  logic [7:0] write_data;
  logic       flag_start_sent;
  logic       flag_address_sent;
  logic       flag_rx_not_empty;
  logic       flag_byte_done;
  logic       flag_tx_empty;
  logic       bus_error;
  logic [7:0] rx_byte;
  logic [7:0] rx_byte_next;
  logic       out_valid;
  logic       out_stall;
  logic [5:0] actions;
  logic [7:0] tx_byte;
  logic [7:0] seconds_bcd;
  logic [7:0] minutes_bcd;
  logic [7:0] hours_bcd;
  logic [7:0] day_bcd;
  logic [7:0] weekday_value;
  logic [7:0] month_bcd;
  logic [7:0] year_bcd;
  logic       all_done;
  logic       error_flag;
  logic       write_accepted;

  // sequencer mirror
  phase_t     seq_phase;
  logic [2:0] req_flags;
  logic [3:0] wr_reg;
  logic [7:0] wr_val;
  logic [7:0] rtc_time [TIME_REGS];
  logic [7:0] addr_wr;
  logic [7:0] addr_rd;
  result_t    cmd_status_q [$];

  int  n_sent, n_checked, mismatches, quiet_cycles;
  int  n_bursts, n_writes_done, n_rejects, n_aborts;
  bit  valid_up, no_gaps, rx_quiet, hold_off;
  result_t got, want;

  i2c_rtc_transaction_sequencer_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .target_register(target_register), .write_data(write_data),
    .flag_start_sent(flag_start_sent), .flag_address_sent(flag_address_sent),
    .flag_rx_not_empty(flag_rx_not_empty), .flag_byte_done(flag_byte_done),
    .flag_tx_empty(flag_tx_empty), .bus_error(bus_error),
    .rx_byte(rx_byte), .rx_byte_next(rx_byte_next),
    .out_valid(out_valid), .out_stall(out_stall),
    .actions(actions), .tx_byte(tx_byte),
    .seconds_bcd(seconds_bcd), .minutes_bcd(minutes_bcd), .hours_bcd(hours_bcd),
    .day_bcd(day_bcd), .weekday_value(weekday_value), .month_bcd(month_bcd),
    .year_bcd(year_bcd), .all_done(all_done), .error_flag(error_flag),
    .write_accepted(write_accepted)
  );

  always #2 clk = ~clk;

  function automatic void advance_sequencer(input item_t it);
    result_t    r;
    logic [5:0] acts;
    logic [7:0] txb;
    logic       taken;
    acts  = '0;
    txb   = '0;
    taken = 1'b0;
    case (it.mode)
      MODE_UPDATE: req_flags |= PF_UPDATE;
      MODE_WRITE: begin
        if ((req_flags & PF_WRITE) == '0 && it.target_register <= MAX_TARGET) begin
          wr_reg    = it.target_register[3:0];
          wr_val    = it.write_data;
          req_flags |= PF_WRITE;
          taken     = 1'b1;
        end else begin
          n_rejects++;
        end
      end
      MODE_EVENT: begin
        if (it.bus_error) begin
          seq_phase = PH_IDLE;
          req_flags = PF_ERROR;
          n_aborts++;
        end
        if (it.flag_start_sent) begin
          case (seq_phase)
            PH_START_WR: begin
              acts |= ACT_SEND; txb = addr_wr; seq_phase = PH_ADDR_WR;
            end
            PH_START_RD: begin
              acts |= ACT_SEND; txb = addr_wr; seq_phase = PH_ADDR_RDWR;
            end
            PH_RESTART_RD: begin
              acts |= ACT_SEND; txb = addr_rd; seq_phase = PH_ADDR_RDRD;
            end
            default: ;
          endcase
        end
        if (it.flag_address_sent) begin
          case (seq_phase)
            PH_ADDR_WR: begin
              acts |= ACT_SEND; txb = {4'h0, wr_reg}; seq_phase = PH_SEND_VAL;
            end
            PH_ADDR_RDWR: begin
              acts |= ACT_SEND | ACT_START | ACT_STOP;
              txb = FIRST_TIME_REG;
              seq_phase = PH_RESTART_RD;
            end
            PH_ADDR_RDRD: begin
              acts |= ACT_ACK; seq_phase = PH_SEC;
            end
            default: ;
          endcase
        end
        if (it.flag_rx_not_empty) begin
          if (seq_phase == PH_YEAR) begin
            rtc_time[6] = it.rx_byte;
            seq_phase   = PH_IDLE;
            rtc_time[0] &= MASK_SEC;
            rtc_time[1] &= MASK_MIN;
            rtc_time[2] &= MASK_HOUR;
            rtc_time[3] &= MASK_DAY;
            rtc_time[4] &= MASK_WDAY;
            rtc_time[5] &= MASK_MONTH;
            req_flags &= ~(PF_UPDATE | PF_ERROR);
            n_bursts++;
          end
          acts |= ACT_BUF_OFF;
        end
        if (it.flag_byte_done) begin
          case (seq_phase)
            PH_SEND_VAL: begin
              if (it.flag_tx_empty) begin
                acts |= ACT_SEND; txb = wr_val; seq_phase = PH_STOP_WR;
              end
            end
            PH_STOP_WR: begin
              acts |= ACT_STOP;
              seq_phase = PH_IDLE;
              req_flags &= ~(PF_WRITE | PF_ERROR);
              n_writes_done++;
            end
            PH_SEC, PH_MIN, PH_HOUR, PH_DAY: begin
              rtc_time[seq_phase - PH_SEC] = it.rx_byte;
              acts |= ACT_ACK;
              seq_phase = phase_t'(seq_phase + 4'd1);
            end
            PH_WDAY: begin
              rtc_time[4] = it.rx_byte;
              rtc_time[5] = it.rx_byte_next;
              acts |= ACT_STOP | ACT_BUF_ON;
              seq_phase = PH_YEAR;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    // an idle sequencer picks up pending work, update first
    if (it.mode != MODE_UNUSED && seq_phase == PH_IDLE) begin
      if ((req_flags & PF_UPDATE) != '0) begin
        seq_phase = PH_START_RD; acts |= ACT_START;
      end else if ((req_flags & PF_WRITE) != '0) begin
        seq_phase = PH_START_WR; acts |= ACT_START;
      end
    end
    r.actions        = acts;
    r.tx_byte        = ((acts & ACT_SEND) != '0) ? txb : 8'h00;
    r.seconds_bcd    = rtc_time[0];
    r.minutes_bcd    = rtc_time[1];
    r.hours_bcd      = rtc_time[2];
    r.day_bcd        = rtc_time[3];
    r.weekday_value  = rtc_time[4];
    r.month_bcd      = rtc_time[5];
    r.year_bcd       = rtc_time[6];
    r.all_done       = (req_flags & (PF_UPDATE | PF_WRITE)) == '0;
    r.error_flag     = (req_flags & PF_ERROR) != '0;
    r.write_accepted = taken;
    cmd_status_q.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t random_item();
    item_t       it;
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    it = bits[$bits(item_t)-1:0];
    return it;
  endfunction

  function automatic item_t write_req(input logic [7:0] reg_idx, input logic [7:0] val);
    item_t it;
    it = '0;
    it.mode = MODE_WRITE;
    it.target_register = reg_idx;
    it.write_data = val;
    return it;
  endfunction

  function automatic item_t ctrl_event(input logic fs, input logic fa, input logic frx,
                                       input logic fbd, input logic fte, input logic berr,
                                       input logic [7:0] rx, input logic [7:0] rxn);
    item_t it;
    it = '0;
    it.mode = MODE_EVENT;
    {it.flag_start_sent, it.flag_address_sent, it.flag_rx_not_empty} = {fs, fa, frx};
    {it.flag_byte_done, it.flag_tx_empty, it.bus_error} = {fbd, fte, berr};
    it.rx_byte = rx;
    it.rx_byte_next = rxn;
    return it;
  endfunction

  // mostly the event the current phase waits for, with random content
  function automatic item_t protocol_item();
    item_t it;
    int    r;
    it = random_item();
    r  = $urandom_range(0, 99);
    if (r < 4) return it;
    if (r < 6) begin
      it.mode = MODE_EVENT;
      it.bus_error = 1'b1;
      return it;
    end
    if (r < 13) begin
      it.mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_UPDATE;
      if ($urandom_range(0, 4) != 0) it.target_register = 8'($urandom_range(0, 15));
      return it;
    end
    {it.flag_start_sent, it.flag_address_sent, it.flag_rx_not_empty} = '0;
    {it.flag_byte_done, it.bus_error} = '0;
    it.mode = MODE_EVENT;
    case (seq_phase)
      PH_IDLE: begin
        if ($urandom_range(0, 9) < 4) begin
          it.mode = MODE_UPDATE;
        end else begin
          it.mode = MODE_WRITE;
          if ($urandom_range(0, 4) != 0) it.target_register = 8'($urandom_range(0, 15));
        end
      end
      PH_START_WR, PH_START_RD, PH_RESTART_RD: it.flag_start_sent = 1'b1;
      PH_ADDR_WR, PH_ADDR_RDWR, PH_ADDR_RDRD: it.flag_address_sent = 1'b1;
      PH_SEND_VAL: begin
        it.flag_byte_done = 1'b1;
        it.flag_tx_empty = ($urandom_range(0, 7) != 0);
      end
      PH_YEAR: it.flag_rx_not_empty = 1'b1;
      default: it.flag_byte_done = 1'b1;
    endcase
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      if (valid_up) begin
        @(negedge clk);
        in_valid <= 1'b0;
        valid_up = 1'b0;
        gap--;
      end
      repeat (gap) @(negedge clk);
    end
    @(negedge clk);
    {mode, target_register, write_data, flag_start_sent, flag_address_sent,
     flag_rx_not_empty, flag_byte_done, flag_tx_empty, bus_error,
     rx_byte, rx_byte_next} <= it;
    in_valid <= 1'b1;
    valid_up = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_sequencer(it);
    n_sent++;
  endtask

  task automatic settle();
    if (valid_up) begin
      @(negedge clk);
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (cmd_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_addresses(input logic [7:0] wa, input logic [7:0] ra);
    settle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_WRITE_ADDR;
    cfg_data  <= wa;
    @(negedge clk);
    cfg_index <= CFG_READ_ADDR;
    cfg_data  <= ra;
    @(negedge clk);
    cfg_write <= 1'b0;
    addr_wr = wa;
    addr_rd = ra;
  endtask

  task automatic test_directed_update();
    item_t it;
    it = '0;
    it.mode = MODE_UPDATE;
    send_item(it);
    send_item(ctrl_event(1, 0, 0, 0, 0, 0, 8'h00, 8'h00));
    send_item(ctrl_event(0, 1, 0, 0, 0, 0, 8'h00, 8'h00));
    send_item(ctrl_event(1, 0, 0, 0, 0, 0, 8'h00, 8'h00));
    send_item(ctrl_event(0, 1, 0, 0, 0, 0, 8'h00, 8'h00));
    repeat (4) send_item(ctrl_event(0, 0, 0, 1, 0, 0, 8'hFF, 8'h00));
    send_item(ctrl_event(0, 0, 0, 1, 0, 0, 8'hFF, 8'hFF));
    send_item(ctrl_event(0, 0, 1, 0, 0, 0, 8'hFF, 8'h00));
  endtask

  task automatic test_directed_write();
    send_item(write_req(8'd15, 8'hFF));
    send_item(write_req(8'hFF, 8'h00));
    send_item(ctrl_event(1, 0, 0, 0, 0, 0, 8'h00, 8'h00));
    send_item(ctrl_event(0, 1, 0, 0, 0, 0, 8'h00, 8'h00));
    send_item(ctrl_event(0, 0, 0, 1, 0, 0, 8'h00, 8'h00));
    send_item(ctrl_event(0, 0, 0, 1, 1, 0, 8'h00, 8'h00));
    send_item(ctrl_event(0, 0, 0, 1, 0, 0, 8'h00, 8'h00));
  endtask

  task automatic test_directed_special();
    item_t it;
    send_item(write_req(8'd16, 8'hAA));
    it = '1;
    it.mode = MODE_UNUSED;
    send_item(it);
    send_item(write_req(8'd0, 8'h00));
    send_item(write_req(8'd3, 8'h01));
    // abort with a start flag that then lands in idle
    send_item(ctrl_event(1, 0, 0, 0, 0, 1, 8'h00, 8'h00));
    it = '0;
    it.mode = MODE_UPDATE;
    send_item(it);
    // several flags in one event chain through phases
    send_item(ctrl_event(1, 1, 0, 0, 0, 0, 8'h00, 8'h00));
    send_item(ctrl_event(1, 1, 0, 0, 0, 0, 8'h00, 8'h00));
    send_item(ctrl_event(0, 0, 1, 1, 1, 0, 8'h00, 8'hFF));
  endtask

  task automatic test_backpressure();
    int k;
    no_gaps = 1'b1;
    rx_quiet = 1'b1;
    hold_off = 1'b1;
    while (hold_off) send_item(protocol_item());
    for (k = 0; k < 20; k++) send_item(protocol_item());
    no_gaps = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_random_phase(input int count, input logic [7:0] wa,
                                   input logic [7:0] ra, input bit quiet);
    int k;
    set_addresses(wa, ra);
    no_gaps = quiet;
    rx_quiet = quiet;
    for (k = 0; k < count; k++) send_item(protocol_item());
    no_gaps = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // output side stall pattern
  initial begin : receiver
    int run;
    bit stall_now;
    run = 0;
    stall_now = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
        run = 0;
      end else begin
        if (run == 0) begin
          stall_now = !rx_quiet && ($urandom_range(0, 2) == 0);
          run = 1 + pick_gap();
        end
        out_stall <= stall_now;
        run--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_checked++;
      got = {actions, tx_byte, seconds_bcd, minutes_bcd, hours_bcd, day_bcd,
             weekday_value, month_bcd, year_bcd, all_done, error_flag, write_accepted};
      if (cmd_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("unexpected result transfer at %0t: %h", $realtime, got);
      end else begin
        want = cmd_status_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT) begin
            $display("mismatch at %0t exp act=%h tx=%h time=%h_%h_%h_%h_%h_%h_%h done=%b err=%b wr=%b",
                     $realtime, want.actions, want.tx_byte, want.seconds_bcd,
                     want.minutes_bcd, want.hours_bcd, want.day_bcd, want.weekday_value,
                     want.month_bcd, want.year_bcd, want.all_done, want.error_flag,
                     want.write_accepted);
            $display("            got act=%h tx=%h time=%h_%h_%h_%h_%h_%h_%h done=%b err=%b wr=%b",
                     got.actions, got.tx_byte, got.seconds_bcd, got.minutes_bcd,
                     got.hours_bcd, got.day_bcd, got.weekday_value, got.month_bcd,
                     got.year_bcd, got.all_done, got.error_flag, got.write_accepted);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_WRITE_ADDR;
    cfg_data = '0;
    in_valid = 1'b0;
    {mode, target_register, write_data, flag_start_sent, flag_address_sent,
     flag_rx_not_empty, flag_byte_done, flag_tx_empty, bus_error,
     rx_byte, rx_byte_next} = '0;
    valid_up = 1'b0;
    no_gaps = 1'b0;
    rx_quiet = 1'b0;
    hold_off = 1'b0;
    quiet_cycles = 0;
    seq_phase = PH_IDLE;
    req_flags = '0;
    wr_reg = '0;
    wr_val = '0;
    for (int i = 0; i < TIME_REGS; i++) rtc_time[i] = '0;
    addr_wr = RESET_WRITE_ADDR;
    addr_rd = RESET_READ_ADDR;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_directed_update();
    test_directed_write();
    test_directed_special();
    test_backpressure();
    test_random_phase(190, 8'h00, 8'hFF, 1'b0);
    test_random_phase(190, 8'hFF, 8'h00, 1'b1);
    test_random_phase(190, 8'($urandom), 8'($urandom), 1'b0);
    test_random_phase(190, 8'($urandom), 8'($urandom), 1'b0);
    test_random_phase(150, RESET_WRITE_ADDR, RESET_READ_ADDR, 1'b0);
    settle();
    repeat (10) @(posedge clk);

    $display("%0d input transfers, %0d results checked, %0d mismatches",
             n_sent, n_checked, mismatches);
    $display("%0d time bursts, %0d register writes, %0d rejected writes, %0d bus aborts",
             n_bursts, n_writes_done, n_rejects, n_aborts);
    if (mismatches == 0 && cmd_status_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
